// ===== hw/rtl/wbps_pkg.sv =====
// Package for the wildcard byte pattern scanner: shared types, register
// codes and limits. No dependencies.
`default_nettype none
package wbps_pkg;

    localparam int PAT_REG_BYTES   = 16;
    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_W        = 32;
    localparam int ADDR_W          = 64;
    localparam int LEN_REG_W       = 5;
    localparam int APB_DATA_W      = 64;
    localparam int APB_ADDR_W      = 5;

    localparam logic [OFFSET_W-1:0] OFFSET_LIMIT = 32'hFFFF_FFFF;
    localparam logic [7:0]          WILDCARD     = 8'h00;

    localparam logic [1:0] REG_PAT_LO = 2'd0;
    localparam logic [1:0] REG_PAT_HI = 2'd1;
    localparam logic [1:0] REG_LEN    = 2'd2;
    localparam logic [1:0] REG_BASE   = 2'd3;

    typedef logic [7:0] t_byte;
    typedef logic [PAT_REG_BYTES-1:0][7:0] t_pat;

    typedef struct packed {
        t_pat                   pat;
        logic [LEN_REG_W-1:0]   len;
        logic [ADDR_W-1:0]      base;
    } t_cfg;

endpackage
`default_nettype wire

// ===== hw/rtl/wbps_if.sv =====
// Stream interfaces of the scanner: byte input and result output.
// Depends on nothing but the port widths of the block.
`default_nettype none
interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] match_address;
    modport source(output valid, output found, output match_address, input ready);
    modport sink(input valid, input found, input match_address, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wbps_cfg.sv =====
// APB-style register file for the scanner: pattern, length and base.
// Depends on wbps_pkg.
`default_nettype none
module wbps_cfg
    import wbps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    output logic      [APB_DATA_W-1:0] o_prdata,
    output t_cfg                       o_cfg
);

    logic [1:0] w_idx;
    logic       w_wr;
    t_cfg       r_cfg;

    assign w_idx = i_paddr[APB_ADDR_W-1:3];
    assign w_wr  = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat  <= '0;
            r_cfg.len  <= LEN_REG_W'(1);
            r_cfg.base <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_PAT_LO: r_cfg.pat[7:0]  <= i_pwdata;
                REG_PAT_HI: r_cfg.pat[15:8] <= i_pwdata;
                REG_LEN:    r_cfg.len       <= i_pwdata[LEN_REG_W-1:0];
                REG_BASE:   r_cfg.base      <= i_pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PAT_LO: o_prdata = r_cfg.pat[7:0];
            REG_PAT_HI: o_prdata = r_cfg.pat[15:8];
            REG_LEN:    o_prdata = {{(APB_DATA_W-LEN_REG_W){1'b0}}, r_cfg.len};
            REG_BASE:   o_prdata = r_cfg.base;
            default:    o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== hw/rtl/wbps_cell.sv =====
// One window cell: holds one byte of the shift window and checks the byte
// entering it against its pattern position. Depends on wbps_pkg.
`default_nettype none
module wbps_cell
    import wbps_pkg::*;
#(
    parameter int IDX = 0,
    parameter int LW  = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_shift,
    input  wire t_byte         i_byte,
    input  wire t_pat          i_pat,
    input  wire logic [LW-1:0] i_len,
    output t_byte              o_byte,
    output logic               o_ok
);

    localparam int JW = (LW > 4) ? LW : 4;

    t_byte          r_byte;
    logic           w_active;
    logic [JW-1:0]  w_j;
    t_byte          w_pat;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // Cell IDX holds window byte IDX, compared with pattern byte len-1-IDX.
    assign w_active = LW'(IDX) < i_len;
    assign w_j      = JW'(i_len - LW'(1) - LW'(IDX));

    always_comb begin
        if (w_j < JW'(PAT_REG_BYTES)) begin
            w_pat = i_pat[w_j[3:0]];
        end else begin
            w_pat = WILDCARD;
        end
    end

    assign o_ok   = !w_active || (w_pat == WILDCARD) || (w_pat == i_byte);
    assign o_byte = r_byte;

endmodule
`default_nettype wire

// ===== hw/rtl/wildcard_byte_pattern_scanner_top.sv =====
// Wildcard byte pattern scanner, top level: cell chain, offset tracking,
// result register. Depends on wbps_pkg, wbps_if, wbps_cfg and wbps_cell.
//
// Usage: program the pattern (bytes 0..15, zero is a wildcard), length and
// region base over the APB port while no region is in flight. Stream one
// region byte per word on i_in, last_byte set on the final byte. Each byte
// enters a row of MAX_PATTERN cells; every cell compares the byte entering
// it against its pattern position in the same cycle, so a byte is taken
// every cycle (one word per cycle sustained) while the output register is empty or being read.
// The first match in a region yields one word on o_out with found set and
// match_address = base + start offset, in the cycle after the byte that
// completes it. Later bytes of the region are taken and dropped. If the
// final byte arrives with no match, a word with found clear and address
// zero follows in the next cycle. Counting restarts at the next region.
// The result sits in an output register; a new byte is taken while that
// register is empty or being read, so a stalled receiver stalls i_in.
// Reset: registers return to pattern zero, length one, base zero, and the
// region state is cleared. pready is always high.
`default_nettype none
module wildcard_byte_pattern_scanner_top
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    wbps_in_if.sink                    i_in,
    wbps_out_if.source                 o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int CW = (LW > LEN_REG_W) ? LW : LEN_REG_W;

    t_cfg                w_cfg;
    logic [CW-1:0]       w_len_ext;
    logic [LW-1:0]       w_len;
    t_byte               w_in_byte [MAX_PATTERN];
    t_byte               w_cell_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_ok;

    logic                r_matched;
    logic [OFFSET_W-1:0] r_offset;
    logic                r_out_valid;
    logic                r_out_found;
    logic [ADDR_W-1:0]   r_out_addr;

    logic                w_accept;
    logic                w_shift;
    logic                w_hit;
    logic                w_emit;
    logic [OFFSET_W-1:0] w_start;

    assign pready = 1'b1;

    wbps_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    // Clamp length into 1..MAX_PATTERN.
    assign w_len_ext = CW'(w_cfg.len);
    always_comb begin
        if (w_len_ext == '0) begin
            w_len = LW'(1);
        end else if (w_len_ext > CW'(MAX_PATTERN)) begin
            w_len = LW'(MAX_PATTERN);
        end else begin
            w_len = w_len_ext[LW-1:0];
        end
    end

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_shift    = w_accept && !r_matched;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_in_byte[g] = i_in.data_byte;
            end else begin : g_link
                assign w_in_byte[g] = w_cell_byte[g-1];
            end
            wbps_cell #(
                .IDX (g),
                .LW  (LW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_byte  (w_in_byte[g]),
                .i_pat   (w_cfg.pat),
                .i_len   (w_len),
                .o_byte  (w_cell_byte[g]),
                .o_ok    (w_ok[g])
            );
        end
    endgenerate

    // Match needs a full window of this region and an unsaturated offset.
    assign w_hit = !r_matched && (r_offset != OFFSET_LIMIT)
                   && (r_offset >= OFFSET_W'(w_len - LW'(1))) && (&w_ok);
    assign w_start = r_offset - OFFSET_W'(w_len - LW'(1));
    assign w_emit  = w_accept && (w_hit || (i_in.last_byte && !r_matched));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matched <= 1'b0;
            r_offset  <= '0;
        end else if (w_accept) begin
            if (i_in.last_byte) begin
                r_matched <= 1'b0;
                r_offset  <= '0;
            end else if (!r_matched) begin
                r_matched <= w_hit;
                if (r_offset != OFFSET_LIMIT) begin
                    r_offset <= r_offset + OFFSET_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_found <= w_hit;
            r_out_addr  <= w_hit ? (w_cfg.base + {{(ADDR_W-OFFSET_W){1'b0}}, w_start})
                                 : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.found         = r_out_found;
    assign o_out.match_address = r_out_addr;

endmodule
`default_nettype wire

// ===== tb/tb_wildcard_byte_pattern_scanner_top.sv =====
// Testbench for the wildcard byte pattern scanner: streams byte regions under
// several pattern setups and checks each result word against an in-bench scan.
// Depends on wbps_pkg, wbps_if and the scanner top level.
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scanner_top
    import wbps_pkg::*;
();

    typedef struct packed {
        t_byte data_byte;
        logic  last_byte;
    } t_scan_word;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_scan_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    wbps_in_if  in_if();
    wbps_out_if out_if();

    wildcard_byte_pattern_scanner_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Register copies and scan state of the in-bench model
    logic [63:0]          cfg_pat_lo;
    logic [63:0]          cfg_pat_hi;
    logic [LEN_REG_W-1:0] cfg_len;
    logic [ADDR_W-1:0]    cfg_base;
    t_byte                scan_window [16];
    logic [OFFSET_W-1:0]  scan_offset;
    bit                   hit_reported;

    t_scan_word   region_bytes_q[$];
    t_scan_result expected_hits_q[$];

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned queued_words;
    int unsigned errors;
    bit          in_taken;
    t_scan_word  next_word;
    t_scan_result got_result;
    t_scan_result want_result;
    t_scan_result new_result;

    function automatic int unsigned active_length();
        if (cfg_len == 0) return 1;
        if (cfg_len > 16) return 16;
        return int'(cfg_len);
    endfunction

    function automatic t_byte pat_byte(input int unsigned j);
        if (j < 8) return cfg_pat_lo[8*j +: 8];
        return cfg_pat_hi[8*(j-8) +: 8];
    endfunction

    function automatic void clear_scan();
        for (int i = 0; i < 16; i++) scan_window[i] = 8'h00;
        scan_offset  = '0;
        hit_reported = 1'b0;
    endfunction

    // Advance the scan by one byte; return 1 when a result word is due
    function automatic bit scan_byte(input t_byte b, input logic last,
                                     output t_scan_result res);
        int unsigned         n;
        bit                  hit;
        bit                  produced;
        logic [OFFSET_W-1:0] pos;
        t_byte               p;
        produced = 1'b0;
        res      = '0;
        if (!hit_reported) begin
            n   = active_length();
            pos = scan_offset;
            for (int i = 15; i > 0; i--) scan_window[i] = scan_window[i-1];
            scan_window[0] = b;
            if (pos != OFFSET_LIMIT && 64'(pos) + 64'd1 >= 64'(n)) begin
                hit = 1'b1;
                for (int j = 0; j < n; j++) begin
                    p = pat_byte(j);
                    if (p != WILDCARD && scan_window[n-1-j] != p) hit = 1'b0;
                end
                if (hit) begin
                    res.found         = 1'b1;
                    res.match_address = cfg_base + 64'(32'(pos + 32'd1 - 32'(n)));
                    hit_reported      = 1'b1;
                    produced          = 1'b1;
                end
            end
            if (scan_offset != OFFSET_LIMIT) scan_offset = scan_offset + 1'b1;
        end
        if (last) begin
            if (!hit_reported) begin
                res.found         = 1'b0;
                res.match_address = '0;
                produced          = 1'b1;
            end
            clear_scan();
        end
        return produced;
    endfunction

    // Driver: hold the word until taken, then present the next one or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (region_bytes_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                next_word = region_bytes_q.pop_front();
                in_if.valid     <= 1'b1;
                in_if.data_byte <= next_word.data_byte;
                in_if.last_byte <= next_word.last_byte;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        out_if.ready <= i_rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor: check result words, then run the scan on each taken byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_if.valid && in_if.ready;
            if (out_if.valid && out_if.ready) begin
                got_result.found         = out_if.found;
                got_result.match_address = out_if.match_address;
                if (expected_hits_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual found=%0b addr=%h",
                             $time, got_result.found, got_result.match_address);
                    errors++;
                end else begin
                    want_result = expected_hits_q.pop_front();
                    if (got_result.found !== want_result.found) begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want_result.found, got_result.found);
                        errors++;
                    end
                    if (got_result.match_address !== want_result.match_address) begin
                        $display("%0t: match_address mismatch: expected %h, actual %h",
                                 $time, want_result.match_address, got_result.match_address);
                        errors++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                if (scan_byte(in_if.data_byte, in_if.last_byte, new_result))
                    expected_hits_q = {expected_hits_q, new_result};
            end
        end
    end

    task automatic push_word(input t_byte d, input logic last);
        t_scan_word w;
        w.data_byte    = d;
        w.last_byte    = last;
        region_bytes_q = {region_bytes_q, w};
        queued_words++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PAT_LO: cfg_pat_lo = value;
            REG_PAT_HI: cfg_pat_hi = value;
            REG_LEN:    cfg_len    = value[LEN_REG_W-1:0];
            REG_BASE:   cfg_base   = value;
            default: ;
        endcase
    endtask

    // Wait until every word is taken and every result has arrived
    task automatic drain();
        while (region_bytes_q.size() != 0 || in_if.valid || expected_hits_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_pattern_word();
        logic [63:0] w;
        for (int k = 0; k < 8; k++)
            w[8*k +: 8] = ($urandom_range(3) == 0) ? WILDCARD : 8'($urandom_range(255, 1));
        return w;
    endfunction

    // One region, optionally carrying the pattern; the copy may be damaged
    // or cut short by the region end
    task automatic queue_region(input bit plant, input bit corrupt);
        int    n;
        int    region_len;
        int    start;
        int    bad_j;
        t_byte d;
        n          = active_length();
        region_len = $urandom_range(2*n + 8, 1);
        start      = $urandom_range(region_len - 1, 0);
        bad_j      = $urandom_range(n - 1, 0);
        for (int k = 0; k < region_len; k++) begin
            d = 8'($urandom);
            if (plant && k >= start && k - start < n) begin
                if (pat_byte(k - start) != WILDCARD) d = pat_byte(k - start);
                if (corrupt && k - start == bad_j) d = d ^ 8'($urandom_range(255, 1));
            end
            push_word(d, k == region_len - 1);
        end
    endtask

    // Region drawn mostly from pattern bytes, so partial matches overlap
    task automatic queue_dense_region();
        int    n;
        int    region_len;
        t_byte d;
        n          = active_length();
        region_len = $urandom_range(3*n + 4, n);
        for (int k = 0; k < region_len; k++) begin
            d = ($urandom_range(3) != 0) ? pat_byte($urandom_range(n - 1, 0)) : 8'($urandom);
            push_word(d, k == region_len - 1);
        end
    endtask

    task automatic queue_noise(input int count);
        for (int k = 0; k < count; k++)
            push_word(8'($urandom), $urandom_range(5) == 0);
    endtask

    task automatic configure_phase(input int phase);
        case (phase)
            0: begin
                write_reg(REG_PAT_LO, 64'h0);
                write_reg(REG_PAT_HI, 64'h0);
                write_reg(REG_LEN, 64'd16);
                write_reg(REG_BASE, 64'h0);
            end
            1: begin
                write_reg(REG_PAT_LO, '1);
                write_reg(REG_PAT_HI, '1);
                write_reg(REG_LEN, 64'd16);
                write_reg(REG_BASE, '1);
            end
            2: begin
                write_reg(REG_PAT_LO, rand_pattern_word());
                write_reg(REG_PAT_HI, rand_pattern_word());
                write_reg(REG_LEN, 64'd0);
                write_reg(REG_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
            end
            3: begin
                write_reg(REG_PAT_LO, rand_pattern_word());
                write_reg(REG_PAT_HI, rand_pattern_word());
                write_reg(REG_LEN, '1);
                write_reg(REG_BASE, {$urandom, $urandom});
            end
            4: begin
                write_reg(REG_PAT_LO, {56'h0, 8'($urandom_range(255, 1))});
                write_reg(REG_PAT_HI, rand_pattern_word());
                write_reg(REG_LEN, 64'd1);
                write_reg(REG_BASE, {$urandom, $urandom});
            end
            5: begin
                write_reg(REG_PAT_LO, rand_pattern_word());
                write_reg(REG_PAT_HI, rand_pattern_word());
                write_reg(REG_LEN, 64'($urandom_range(30, 17)));
                write_reg(REG_BASE, {$urandom, $urandom});
            end
            default: begin
                write_reg(REG_PAT_LO, rand_pattern_word());
                write_reg(REG_PAT_HI, rand_pattern_word());
                write_reg(REG_LEN, 64'($urandom_range(16, 1)));
                write_reg(REG_BASE, {$urandom, $urandom});
            end
        endcase
    endtask

    initial begin
        int unsigned target;
        int unsigned pick;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'h00;
        in_if.last_byte = 1'b0;
        out_if.ready    = 1'b0;
        src_idle_pct    = 16;
        sink_stall_pct  = 82;
        queued_words    = 0;
        errors          = 0;
        cfg_pat_lo      = '0;
        cfg_pat_hi      = '0;
        cfg_len         = LEN_REG_W'(1);
        cfg_base        = '0;
        clear_scan();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setup: a single wildcard hits on the first byte; last after a hit is silent
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b1);
        drain();

        // Pattern AA 55 with a trailing wildcard, base at the top of the address space
        write_reg(REG_PAT_LO, 64'h0000_0000_0000_55AA);
        write_reg(REG_PAT_HI, 64'h0);
        write_reg(REG_LEN, 64'd3);
        write_reg(REG_BASE, '1);
        push_word(8'h11, 1'b0);
        push_word(8'hAA, 1'b0);
        push_word(8'h55, 1'b0);
        push_word(8'h77, 1'b0);
        push_word(8'hFF, 1'b1);
        // region shorter than the pattern
        push_word(8'hAA, 1'b0);
        push_word(8'h55, 1'b1);
        // hit completed by the final byte
        push_word(8'hAA, 1'b0);
        push_word(8'h55, 1'b0);
        push_word(8'h99, 1'b1);
        // hit would need a byte past the region end
        push_word(8'h00, 1'b0);
        push_word(8'hAA, 1'b0);
        push_word(8'h55, 1'b1);

        for (int phase = 0; phase < 9; phase++) begin
            drain();
            if (phase < 3) begin
                src_idle_pct   = 16;
                sink_stall_pct = 82;
            end else if (phase < 6) begin
                src_idle_pct   = 82;
                sink_stall_pct = 16;
            end else begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            configure_phase(phase);
            target = queued_words + 135;
            while (queued_words < target) begin
                pick = $urandom_range(9);
                if (pick < 4)       queue_region(1'b1, 1'b0);
                else if (pick < 6)  queue_region(1'b1, 1'b1);
                else if (pick < 7)  queue_region(1'b0, 1'b0);
                else if (pick < 8)  queue_dense_region();
                else if (pick < 9)  queue_noise($urandom_range(12, 1));
                else                push_word(8'($urandom), 1'b1);
            end
        end
        // close any region left open by noise
        push_word(8'($urandom), 1'b1);

        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/wbps_pkg.sv
hw/rtl/wbps_if.sv
hw/rtl/wbps_cfg.sv
hw/rtl/wbps_cell.sv
hw/rtl/wildcard_byte_pattern_scanner_top.sv
tb/tb_wildcard_byte_pattern_scanner_top.sv
